FILE: rtl/core/slc_pkg.sv
// Shared types, codes and defaults for the set-associative LRU cache model.
`timescale 1ns / 1ps

package slc_pkg;

	localparam int unsigned DEF_MAX_SET_BITS = 6;
	localparam int unsigned DEF_MAX_WAYS     = 8;
	localparam int unsigned DEF_ADDR_WIDTH   = 64;

	localparam int unsigned STAMP_W = 64;
	localparam int unsigned AGE_W   = 32;
	localparam int unsigned CNT_W   = 32;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_MODIFY = 2'd2;
	localparam logic [1:0] ACT_OTHER  = 2'd3;

	localparam logic [1:0] OUT_NONE  = 2'd0;
	localparam logic [1:0] OUT_HIT   = 2'd1;
	localparam logic [1:0] OUT_MISS  = 2'd2;
	localparam logic [1:0] OUT_EVICT = 2'd3;

	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_WAYS       = 2'd1;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

	localparam logic [2:0] RST_SET_BITS   = 3'd4;
	localparam logic [3:0] RST_WAYS       = 4'd1;
	localparam logic [5:0] RST_BLOCK_BITS = 6'd4;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [3:0] ways;
		logic [5:0] block_bits;
	} slc_cfg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_COMMIT
	} slc_state_t;

	typedef struct packed {
		logic clr_wr;
		logic take;
		logic look;
		logic commit;
	} slc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_busy;
	} slc_stat_t;

endpackage

FILE: rtl/core/slc_if.sv
// Valid/ready channel interfaces for trace items and result items.
`timescale 1ns / 1ps

interface slc_in_if #(parameter int unsigned ADDR_WIDTH = 64);
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [ADDR_WIDTH-1:0] address;

	modport source (output valid, output action, output address, input ready);
	modport sink   (input valid, input action, input address, output ready);
endinterface

interface slc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic        second_hit;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] eviction_total;

	modport source (output valid, output outcome, output second_hit, output hit_total,
		output miss_total, output eviction_total, input ready);
	modport sink   (input valid, input outcome, input second_hit, input hit_total,
		input miss_total, input eviction_total, output ready);
endinterface

FILE: rtl/core/slc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module slc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/slc_ctrl.sv
// Sequencing state machine: clearing pass, accept, lookup and commit.
`timescale 1ns / 1ps

module slc_ctrl
	import slc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  slc_stat_t stat,
	output slc_cmd_t  cmd
);

	slc_state_t state_q;
	slc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_LOOKUP: begin
				cmd.look = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/slc_dp.sv
// Datapath: address split, set row RAM, way compare, LRU victim, totals, result register.
`timescale 1ns / 1ps

module slc_dp
	import slc_pkg::*;
#(
	parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
	parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slc_cfg_t              cfg,
	input  slc_cmd_t              cmd,
	output slc_stat_t             stat,
	input  logic [1:0]            in_action,
	input  logic [ADDR_WIDTH-1:0] in_address,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [1:0]            outcome,
	output logic                  second_hit,
	output logic [CNT_W-1:0]      hit_total,
	output logic [CNT_W-1:0]      miss_total,
	output logic [CNT_W-1:0]      eviction_total
);

	localparam int unsigned SET_W = MAX_SET_BITS;
	localparam int unsigned SETS  = 1 << MAX_SET_BITS;
	localparam int unsigned SBW   = $clog2(MAX_SET_BITS + 1);
	localparam int unsigned WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned EW    = 1 + ADDR_WIDTH + STAMP_W;
	localparam int unsigned ROW_W = MAX_WAYS * EW;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
		return (&x) ? x : x + CNT_W'(1);
	endfunction

	// address split
	logic [SBW-1:0]        sb;
	logic [6:0]            tag_sh;
	logic [ADDR_WIDTH-1:0] blk;
	logic [SET_W:0]        set_mask;
	logic [SET_W-1:0]      in_set;
	logic [ADDR_WIDTH-1:0] in_tag;

	always_comb begin
		if (int'(cfg.set_bits) > int'(MAX_SET_BITS)) begin
			sb = SBW'(MAX_SET_BITS);
		end else begin
			sb = SBW'(cfg.set_bits);
		end
		tag_sh   = 7'(cfg.block_bits) + 7'(sb);
		blk      = in_address >> cfg.block_bits;
		in_tag   = in_address >> tag_sh;
		set_mask = ((SET_W + 1)'(1) << sb) - (SET_W + 1)'(1);
		in_set   = blk[SET_W-1:0] & set_mask[SET_W-1:0];
	end

	logic [1:0]            action_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [SET_W-1:0]      set_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			action_q <= in_action;
			tag_q    <= in_tag;
			set_q    <= in_set;
		end
	end

	// clearing pass and input stamp counter
	logic [SET_W-1:0]   clr_row_q;
	logic [STAMP_W-1:0] now_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
			now_q     <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_row_q <= clr_row_q + SET_W'(1);
			end
			if (cmd.commit) begin
				now_q <= now_q + STAMP_W'(1);
			end
		end
	end

	// row memory
	logic             ram_we;
	logic [SET_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] new_row;
	logic             access;

	assign access    = (action_q != ACT_OTHER);
	assign ram_we    = cmd.clr_wr | (cmd.commit & access);
	assign ram_waddr = cmd.clr_wr ? clr_row_q : set_q;
	assign ram_wdata = cmd.clr_wr ? '0 : new_row;

	slc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.take),
		.raddr (in_set),
		.rdata (ram_rdata)
	);

	// lookup: tag compare and age per way
	logic [MAX_WAYS-1:0] use_c;
	logic [MAX_WAYS-1:0] vld_c;
	logic [MAX_WAYS-1:0] hit_c;
	logic [AGE_W-1:0]    age_c [MAX_WAYS];

	always_comb begin
		logic [EW-1:0]      ent;
		logic [STAMP_W-1:0] diff;
		for (int w = 0; w < MAX_WAYS; w++) begin
			ent = ram_rdata[w*EW +: EW];
			diff = now_q - ent[STAMP_W-1:0];
			if (cfg.ways == '0) begin
				use_c[w] = (w == 0);
			end else begin
				use_c[w] = (5'(w) < {1'b0, cfg.ways});
			end
			vld_c[w] = ent[EW-1] & use_c[w];
			hit_c[w] = vld_c[w] & (ent[STAMP_W +: ADDR_WIDTH] == tag_q);
			age_c[w] = (|diff[STAMP_W-1:AGE_W]) ? '1 : diff[AGE_W-1:0];
		end
	end

	logic [MAX_WAYS-1:0] vld_s1;
	logic [MAX_WAYS-1:0] hit_s1;
	logic [AGE_W-1:0]    age_s1 [MAX_WAYS];

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			vld_s1 <= vld_c;
			hit_s1 <= hit_c;
			age_s1 <= age_c;
		end
	end

	// commit: way choice and row update
	logic             hit_any;
	logic             free_any;
	logic [WW-1:0]    hit_way;
	logic [WW-1:0]    free_way;
	logic [WW-1:0]    victim;
	logic [AGE_W-1:0] oldest;
	logic [WW-1:0]    touch_way;
	logic [1:0]       outcome_c;

	always_comb begin
		logic [MAX_WAYS-1:0] free_v;
		free_v   = use_c & ~vld_s1;
		hit_any  = |hit_s1;
		free_any = |free_v;
		hit_way  = '0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hit_s1[w]) begin
				hit_way = WW'(w);
			end
			if (free_v[w]) begin
				free_way = WW'(w);
			end
		end
		victim = '0;
		oldest = age_s1[0];
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (use_c[w] && (age_s1[w] > oldest)) begin
				oldest = age_s1[w];
				victim = WW'(w);
			end
		end
		if (hit_any) begin
			touch_way = hit_way;
			outcome_c = OUT_HIT;
		end else if (free_any) begin
			touch_way = free_way;
			outcome_c = OUT_MISS;
		end else begin
			touch_way = victim;
			outcome_c = OUT_EVICT;
		end
		if (!access) begin
			outcome_c = OUT_NONE;
		end
		new_row = ram_rdata;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WW'(w) == touch_way) begin
				new_row[w*EW +: EW] = {1'b1, tag_q, now_q};
			end
		end
	end

	// totals
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] evicts_q;
	logic [CNT_W-1:0] hits_first;

	assign hits_first = (outcome_c == OUT_HIT) ? sat_inc(hits_q) : hits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (cmd.commit) begin
			hits_q <= (action_q == ACT_MODIFY) ? sat_inc(hits_first) : hits_first;
			if ((outcome_c == OUT_MISS) || (outcome_c == OUT_EVICT)) begin
				misses_q <= sat_inc(misses_q);
			end
			if (outcome_c == OUT_EVICT) begin
				evicts_q <= sat_inc(evicts_q);
			end
		end
	end

	// result register; totals stay put until the next commit, which waits for it to drain
	logic       out_valid_q;
	logic [1:0] outcome_q;
	logic       second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			outcome_q <= outcome_c;
			second_q  <= (action_q == ACT_MODIFY);
		end
	end

	assign stat.clr_last = &clr_row_q;
	assign stat.out_busy = out_valid_q & ~out_ready;

	assign out_valid      = out_valid_q;
	assign outcome        = outcome_q;
	assign second_hit     = second_q;
	assign hit_total      = hits_q;
	assign miss_total     = misses_q;
	assign eviction_total = evicts_q;

endmodule

FILE: rtl/core/set_assoc_lru_cache_model_top.sv
// Top level of the set-associative LRU cache model: channels, config registers, core.
//
// Trace items enter on req (action, address) with valid/ready; one result item per
// trace item leaves on rsp (outcome, second_hit and the three running totals).
// An item passes through accept, row read and tag compare, then the commit that
// picks the way, writes the set row back and loads the result register. The next
// item is taken only after the commit, so one item is handled at a time: the
// registered row read, the compare stage and the row write-back run one after the
// other.
// Line ages are kept as input stamps, so all lines age without being rewritten.
// After reset the set memory is swept once to clear the valid bits of all
// 2**MAX_SET_BITS rows (64 by default) with req.ready low; config writes still work.
// A stalled rsp holds its item; the block accepts one more item and then waits in
// the commit step until the result register drains.
// Config is a readable APB write port, always ready: set_bits at 0x0, ways at 0x4,
// block_bits at 0x8. Write it only while no item is in flight.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_top
	import slc_pkg::*;
#(
	parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
	parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	slc_in_if.sink      req,
	slc_out_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	slc_cfg_t  cfg_q;
	slc_cmd_t  cmd;
	slc_stat_t stat;
	logic      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits   <= RST_SET_BITS;
			cfg_q.ways       <= RST_WAYS;
			cfg_q.block_bits <= RST_BLOCK_BITS;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SET_BITS:   cfg_q.set_bits   <= pwdata[2:0];
				REG_WAYS:       cfg_q.ways       <= pwdata[3:0];
				REG_BLOCK_BITS: cfg_q.block_bits <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SET_BITS:   prdata = 32'(cfg_q.set_bits);
			REG_WAYS:       prdata = 32'(cfg_q.ways);
			REG_BLOCK_BITS: prdata = 32'(cfg_q.block_bits);
			default:        prdata = '0;
		endcase
	end

	slc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	slc_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.stat           (stat),
		.in_action      (req.action),
		.in_address     (req.address),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.outcome        (rsp.outcome),
		.second_hit     (rsp.second_hit),
		.hit_total      (rsp.hit_total),
		.miss_total     (rsp.miss_total),
		.eviction_total (rsp.eviction_total)
	);

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the set-associative LRU cache model top level.
`timescale 1ns / 1ps

module tb;
	import slc_pkg::*;

	localparam int unsigned LINE_COUNT     = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
	localparam int unsigned STALL_LIMIT    = 5000;
	localparam int unsigned PHASE_COUNT    = 8;
	localparam int unsigned PHASE_ITEMS    = 60;
	localparam int unsigned POOL_SIZE      = 24;
	localparam int unsigned QUIET_PHASE    = 5;

	typedef struct packed {
		logic [1:0]  outcome;
		logic        second_hit;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} trace_result_t;

	typedef struct packed {
		logic          is_cfg;
		logic [1:0]    code;
		logic [63:0]   value;
		logic          fixed;
		trace_result_t want;
	} stim_row_t;

	localparam trace_result_t NO_FIX = '0;

	// reset config: 16 sets, 1 way, 16-byte blocks
	localparam stim_row_t TRACE_PLAN [0:34] = '{
		'{1'b0, ACT_LOAD,   64'h0,                 1'b1, '{OUT_MISS,  1'b0, 32'd0, 32'd1, 32'd0}},
		'{1'b0, ACT_STORE,  64'h0,                 1'b1, '{OUT_HIT,   1'b0, 32'd1, 32'd1, 32'd0}},
		'{1'b0, ACT_LOAD,   64'hF,                 1'b1, '{OUT_HIT,   1'b0, 32'd2, 32'd1, 32'd0}},
		'{1'b0, ACT_LOAD,   64'h100,               1'b1, '{OUT_EVICT, 1'b0, 32'd2, 32'd2, 32'd1}},
		'{1'b0, ACT_MODIFY, 64'h100,               1'b1, '{OUT_HIT,   1'b1, 32'd4, 32'd2, 32'd1}},
		'{1'b0, ACT_MODIFY, 64'h200,               1'b1, '{OUT_EVICT, 1'b1, 32'd5, 32'd3, 32'd2}},
		'{1'b0, ACT_OTHER,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{OUT_NONE, 1'b0, 32'd5, 32'd3, 32'd2}},
		'{1'b0, ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{OUT_MISS, 1'b0, 32'd5, 32'd4, 32'd2}},
		'{1'b0, ACT_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{OUT_HIT,  1'b0, 32'd6, 32'd4, 32'd2}},
		'{1'b0, ACT_LOAD,   64'h8000_0000_0000_0000, 1'b1, '{OUT_EVICT, 1'b0, 32'd6, 32'd5, 32'd3}},
		'{1'b0, ACT_MODIFY, 64'h5555_5555_5555_5555, 1'b1, '{OUT_MISS, 1'b1, 32'd7, 32'd6, 32'd3}},
		'{1'b0, ACT_OTHER,  64'h0,                 1'b1, '{OUT_NONE,  1'b0, 32'd7, 32'd6, 32'd3}},
		'{1'b0, ACT_LOAD,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{OUT_MISS, 1'b0, 32'd7, 32'd7, 32'd3}},
		// two ways: LRU order
		'{1'b1, REG_WAYS,       64'd2,             1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h000,               1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h100,               1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h010,               1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h000,               1'b0, NO_FIX},
		// single set, no block offset
		'{1'b1, REG_SET_BITS,   64'd0,             1'b0, NO_FIX},
		'{1'b1, REG_BLOCK_BITS, 64'd0,             1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h1,                 1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h2,                 1'b0, NO_FIX},
		'{1'b0, ACT_MODIFY, 64'h3,                 1'b0, NO_FIX},
		// set bits and ways above range, widest block offset
		'{1'b1, REG_SET_BITS,   64'd7,             1'b0, NO_FIX},
		'{1'b1, REG_WAYS,       64'd15,            1'b0, NO_FIX},
		'{1'b1, REG_BLOCK_BITS, 64'd63,            1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_FIX},
		'{1'b0, ACT_STORE,  64'h0,                 1'b0, NO_FIX},
		// offset plus index reaches 64: tag is zero
		'{1'b1, REG_SET_BITS,   64'd4,             1'b0, NO_FIX},
		'{1'b1, REG_BLOCK_BITS, 64'd60,            1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'hF000_0000_0000_0000, 1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h1000_0000_0000_0000, 1'b0, NO_FIX},
		// zero ways acts as one
		'{1'b1, REG_WAYS,       64'd0,             1'b0, NO_FIX},
		'{1'b0, ACT_LOAD,   64'h0,                 1'b0, NO_FIX}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	slc_in_if #(.ADDR_WIDTH(DEF_ADDR_WIDTH)) req_ch ();
	slc_out_if rsp_ch ();

	set_assoc_lru_cache_model_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow cache
	bit          line_valid [LINE_COUNT];
	logic [63:0] line_tag [LINE_COUNT];
	bit [31:0]   line_age [LINE_COUNT];
	bit [31:0]   hits_n;
	bit [31:0]   misses_n;
	bit [31:0]   evicts_n;
	logic [2:0]  cfg_set_bits   = RST_SET_BITS;
	logic [3:0]  cfg_ways       = RST_WAYS;
	logic [5:0]  cfg_block_bits = RST_BLOCK_BITS;

	trace_result_t pending_results [$];
	int unsigned   mismatches;
	int unsigned   items_sent;
	int unsigned   reg_writes;
	int unsigned   stall_cycles;
	bit            calm;

	function automatic bit [31:0] bump(input bit [31:0] x);
		return (x == '1) ? x : x + 1;
	endfunction

	function automatic logic [1:0] cache_access(input logic [63:0] addr);
		int unsigned sb;
		int unsigned nw;
		int unsigned set_idx;
		int unsigned base;
		int unsigned victim;
		logic [63:0] tag;
		bit [31:0]   oldest;
		sb = (cfg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : cfg_set_bits;
		nw = (cfg_ways == 0) ? 1 : ((cfg_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : cfg_ways);
		tag = (cfg_block_bits + sb < 64) ? addr >> (cfg_block_bits + sb) : '0;
		set_idx = int'((addr >> cfg_block_bits) & ((64'd1 << sb) - 1));
		base = set_idx * DEF_MAX_WAYS;
		for (int w = 0; w < nw; w++) begin
			if (line_valid[base + w] && line_tag[base + w] == tag) begin
				line_age[base + w] = 0;
				hits_n = bump(hits_n);
				return OUT_HIT;
			end
		end
		misses_n = bump(misses_n);
		for (int w = 0; w < nw; w++) begin
			if (!line_valid[base + w]) begin
				line_valid[base + w] = 1'b1;
				line_tag[base + w] = tag;
				line_age[base + w] = 0;
				return OUT_MISS;
			end
		end
		evicts_n = bump(evicts_n);
		victim = 0;
		oldest = line_age[base];
		for (int w = 1; w < nw; w++) begin
			if (line_age[base + w] > oldest) begin
				oldest = line_age[base + w];
				victim = w;
			end
		end
		line_tag[base + victim] = tag;
		line_age[base + victim] = 0;
		return OUT_EVICT;
	endfunction

	function automatic trace_result_t predict_trace(input logic [1:0] act, input logic [63:0] addr);
		trace_result_t r;
		r = '0;
		r.outcome = OUT_NONE;
		if (act != ACT_OTHER)
			r.outcome = cache_access(addr);
		if (act == ACT_MODIFY)
			r.second_hit = (cache_access(addr) == OUT_HIT);
		for (int i = 0; i < LINE_COUNT; i++) begin
			if (line_valid[i])
				line_age[i] = bump(line_age[i]);
		end
		r.hit_total = hits_n;
		r.miss_total = misses_n;
		r.eviction_total = evicts_n;
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", what);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
	end

	// result checker
	always @(posedge clk) begin
		trace_result_t got;
		trace_result_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = '{rsp_ch.outcome, rsp_ch.second_hit, rsp_ch.hit_total,
				rsp_ch.miss_total, rsp_ch.eviction_total};
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					flag_mismatch($sformatf("expected %p, got %p", want, got));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_trace(input logic [1:0] act, input logic [63:0] addr, input bit fixed,
			input trace_result_t want);
		trace_result_t guess;
		while (!calm && $urandom_range(0, 99) < 30) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.address <= addr;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		guess = predict_trace(act, addr);
		pending_results.push_back(fixed ? want : guess);
		items_sent++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SET_BITS: begin
				cfg_set_bits = val[2:0];
				readback = {29'd0, val[2:0]};
			end
			REG_WAYS: begin
				cfg_ways = val[3:0];
				readback = {28'd0, val[3:0]};
			end
			default: begin
				cfg_block_bits = val[5:0];
				readback = {26'd0, val[5:0]};
			end
		endcase
		reg_writes++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== readback)
			flag_mismatch($sformatf("register %0d read %h, expected %h", idx, prdata, readback));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [63:0] pool [POOL_SIZE];
		logic [63:0] set_mask;
		logic [63:0] off_mask;
		logic [63:0] addr;
		logic [2:0]  sb_new;
		logic [3:0]  ways_new;
		logic [5:0]  blk_new;
		int unsigned sb;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_LOAD;
		req_ch.address <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		calm = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (TRACE_PLAN[i]) begin
			if (TRACE_PLAN[i].is_cfg) begin
				wait_drained();
				write_register(TRACE_PLAN[i].code, TRACE_PLAN[i].value[31:0]);
			end else begin
				send_trace(TRACE_PLAN[i].code, TRACE_PLAN[i].value, TRACE_PLAN[i].fixed,
					TRACE_PLAN[i].want);
			end
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_drained();
			case (ph)
				0: {sb_new, ways_new, blk_new} = {3'd7, 4'd15, 6'd0};
				1: {sb_new, ways_new, blk_new} = {3'd0, 4'd1, 6'd63};
				2: {sb_new, ways_new, blk_new} = {3'd6, 4'd8, 6'd1};
				3: {sb_new, ways_new, blk_new} = {3'd1, 4'd0, 6'd32};
				default: begin
					sb_new = 3'($urandom_range(0, 7));
					ways_new = 4'($urandom_range(0, 15));
					blk_new = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 8))
						: 6'($urandom_range(0, 63));
				end
			endcase
			// junk in the unused upper bits must be ignored
			write_register(REG_SET_BITS, {$urandom} << 3 | 32'(sb_new));
			write_register(REG_WAYS, {$urandom} << 4 | 32'(ways_new));
			write_register(REG_BLOCK_BITS, {$urandom} << 6 | 32'(blk_new));
			calm = (ph == QUIET_PHASE);

			// pool crowded into at most two sets to force hits and evictions
			sb = (cfg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : cfg_set_bits;
			set_mask = ((64'd1 << sb) - 1) << cfg_block_bits;
			off_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << cfg_block_bits);
			foreach (pool[k])
				pool[k] = ({$urandom, $urandom} & ~set_mask) |
					((64'($urandom_range(0, 1)) << cfg_block_bits) & set_mask);

			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 75)
					addr = pool[$urandom_range(0, POOL_SIZE - 1)] ^ ({$urandom, $urandom} & off_mask);
				else
					addr = {$urandom, $urandom};
				send_trace(2'($urandom_range(0, 3)), addr, 1'b0, NO_FIX);
			end
		end

		calm = 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d trace items with %0d register writes", items_sent, reg_writes);
		$display("cache totals: %0d hits, %0d misses, %0d evictions", hits_n, misses_n, evicts_n);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/slc_pkg.sv
rtl/core/slc_if.sv
rtl/core/slc_ram.sv
rtl/core/slc_ctrl.sv
rtl/core/slc_dp.sv
rtl/core/set_assoc_lru_cache_model_top.sv
tb/tb.sv
